// File: hw/rtl/bnts_pkg.sv
// ----------------------------------------------------------------------------
// bnts_pkg
// Shared constants and controller/datapath interface types for the best
// node triple search block.
// ----------------------------------------------------------------------------
package bnts_pkg;

  localparam int MAX_NODES = 256;
  localparam int NODE_AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int IDX_W     = 8;

  // item kinds
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_JOB  = 1'b1;

  // register map: word index taken from paddr[2]
  localparam int   REG_IDX_W   = 1;
  localparam logic REG_LAT_OVH = 1'b0;

  typedef struct packed {
    logic               wr_en;
    logic [NODE_AW-1:0] wr_addr;
    logic [NODE_AW-1:0] rd_addr;
    logic               job_load;
    logic               cap_a;
    logic               cap_b;
    logic               pair_ne;
    logic               issue;
    logic               k_ne;
    logic [NODE_AW-1:0] i_idx;
    logic [NODE_AW-1:0] j_idx;
    logic [NODE_AW-1:0] k_idx;
    logic               out_load;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } stat_t;

endpackage

// File: hw/rtl/best_node_triple_search_core.sv
// ----------------------------------------------------------------------------
// best_node_triple_search_core
// Loads candidate nodes into a store and, on a job beat, searches all sets
// of one to three stored nodes for the lowest-cost set meeting the job.
// ----------------------------------------------------------------------------
// channel   dir   handshake             payload
// in        in    in_valid/in_ready     kind, node_*, job_*
// out       out   out_valid/out_ready   found, cost, first/second/third_index
// cfg       in    apb psel/penable      latency_overhead at byte address 0
//
// node beats are written into the store while it is not full; during a job,
// triples are issued one per cycle while k sweeps the store, through the
// 4-stage cost pipeline fed by the single store read port.
// in_ready is low from job accept until its result sits in the output register;
// a stalled out beat holds the next job in the finish state with in_ready low,
// node beats ahead of that job still go.
// rst is synchronous; store contents are not cleared, only the node count.
// ----------------------------------------------------------------------------
module best_node_triple_search_core import bnts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [11:0]         node_resource,
  input  logic [11:0]         node_bandwidth,
  input  logic [15:0]         node_latency,
  input  logic [11:0]         job_resource,
  input  logic [11:0]         job_bandwidth,
  input  logic [15:0]         job_latency,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output logic signed [29:0]  cost,
  output logic [IDX_W-1:0]    first_index,
  output logic [IDX_W-1:0]    second_index,
  output logic [IDX_W-1:0]    third_index,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cmd_t                 cmd;
  stat_t                stat;
  logic [15:0]          latency_overhead;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      latency_overhead <= '0;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_LAT_OVH) begin
      latency_overhead <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_LAT_OVH) begin
      prdata = {16'd0, latency_overhead};
    end
  end

  bnts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bnts_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .node_resource    (node_resource),
    .node_bandwidth   (node_bandwidth),
    .node_latency     (node_latency),
    .job_resource     (job_resource),
    .job_bandwidth    (job_bandwidth),
    .job_latency      (job_latency),
    .latency_overhead (latency_overhead),
    .found            (found),
    .cost             (cost),
    .first_index      (first_index),
    .second_index     (second_index),
    .third_index      (third_index)
  );

  // no input taken while the cost pipeline is still evaluating triples
  assert property (@(posedge clk) disable iff (rst) stat.pipe_busy |-> !in_ready)
    else $error("input accepted during search");

  // an empty result carries zero cost and zero indices
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (cost == 30'sd0 && first_index == '0 &&
                               second_index == '0 && third_index == '0))
    else $error("empty result has nonzero payload");

  // reported triple is ordered and its cost cannot undercut the latency bound
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (first_index <= second_index &&
                              second_index <= third_index &&
                              cost >= -30'sd65535))
    else $error("found result out of range");

  // a job result leaves the store empty until new nodes arrive
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (cmd.wr_addr == '0))
    else $error("node count not cleared after job");

endmodule

// File: hw/rtl/bnts_dp.sv
// ----------------------------------------------------------------------------
// bnts_dp
// Node store, pair/triple accumulation pipeline, cost evaluation and best
// tracking, plus the result register.
// ----------------------------------------------------------------------------
module bnts_dp import bnts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [11:0]         node_resource,
  input  logic [11:0]         node_bandwidth,
  input  logic [15:0]         node_latency,
  input  logic [11:0]         job_resource,
  input  logic [11:0]         job_bandwidth,
  input  logic [15:0]         job_latency,
  input  logic [15:0]         latency_overhead,
  output logic                found,
  output logic signed [29:0]  cost,
  output logic [IDX_W-1:0]    first_index,
  output logic [IDX_W-1:0]    second_index,
  output logic [IDX_W-1:0]    third_index
);

  // node store: {resource, bandwidth, latency}
  logic [39:0] node_mem [MAX_NODES];
  logic [39:0] rd_data;
  logic [11:0] rd_r;
  logic [11:0] rd_b;
  logic [15:0] rd_l;

  logic [11:0] need_r;
  logic [11:0] need_b;
  logic [16:0] budget;

  logic [11:0] a_r;
  logic [11:0] a_b;
  logic [15:0] a_l;

  // budget minus two latencies can reach -196605
  logic [18:0] l2;
  logic [12:0] r2;
  logic [12:0] b2;
  logic [NODE_AW-1:0] cur_i;
  logic [NODE_AW-1:0] cur_j;

  // stage 1: read data arrives
  logic               v1;
  logic               ne1;
  logic [NODE_AW-1:0] k1;
  logic [11:0]        add_r;
  logic [11:0]        add_b;
  logic [15:0]        add_l;
  logic [19:0]        l3_s1;
  logic [14:0]        rs_s1;
  logic [14:0]        bs_s1;

  // stage 2: surpluses
  logic               v2;
  logic               ok2;
  logic [NODE_AW-1:0] k2;
  logic [13:0]        rs2;
  logic [13:0]        bs2;
  logic [15:0]        l3_2;

  // stage 3: squares
  logic               v3;
  logic               ok3;
  logic [NODE_AW-1:0] k3;
  logic [27:0]        sqr3;
  logic [27:0]        sqb3;
  logic [15:0]        l3_3;

  // stage 4: cost
  logic               v4;
  logic               ok4;
  logic [NODE_AW-1:0] k4;
  logic [29:0]        cost4;

  logic               best_found;
  logic [29:0]        best;
  logic [NODE_AW-1:0] best_i;
  logic [NODE_AW-1:0] best_j;
  logic [NODE_AW-1:0] best_k;
  logic               better;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      node_mem[cmd.wr_addr] <= {node_resource, node_bandwidth, node_latency};
    end
    rd_data <= node_mem[cmd.rd_addr];
  end

  assign rd_r = rd_data[39:28];
  assign rd_b = rd_data[27:16];
  assign rd_l = rd_data[15:0];

  always_ff @(posedge clk) begin
    if (cmd.job_load) begin
      need_r <= job_resource;
      need_b <= job_bandwidth;
      budget <= {1'b0, job_latency} - {1'b0, latency_overhead};
    end
    if (cmd.cap_a) begin
      a_r <= rd_r;
      a_b <= rd_b;
      a_l <= rd_l;
    end
    if (cmd.cap_b) begin
      l2    <= {{2{budget[16]}}, budget} - {3'b000, a_l}
               - (cmd.pair_ne ? {3'b000, rd_l} : 19'd0);
      r2    <= {1'b0, a_r} + (cmd.pair_ne ? {1'b0, rd_r} : 13'd0);
      b2    <= {1'b0, a_b} + (cmd.pair_ne ? {1'b0, rd_b} : 13'd0);
      cur_i <= cmd.i_idx;
      cur_j <= cmd.j_idx;
    end
  end

  assign add_r = ne1 ? rd_r : 12'd0;
  assign add_b = ne1 ? rd_b : 12'd0;
  assign add_l = ne1 ? rd_l : 16'd0;
  assign l3_s1 = {l2[18], l2} - {4'b0000, add_l};
  assign rs_s1 = {2'b00, r2} + {3'b000, add_r} - {3'b000, need_r};
  assign bs_s1 = {2'b00, b2} + {3'b000, add_b} - {3'b000, need_b};

  // pipeline payload
  always_ff @(posedge clk) begin
    ne1   <= cmd.k_ne;
    k1    <= cmd.k_idx;
    ok2   <= !l3_s1[19] && !rs_s1[14] && !bs_s1[14];
    k2    <= k1;
    rs2   <= rs_s1[13:0];
    bs2   <= bs_s1[13:0];
    l3_2  <= l3_s1[15:0];
    ok3   <= ok2;
    k3    <= k2;
    sqr3  <= rs2 * rs2;
    sqb3  <= bs2 * bs2;
    l3_3  <= l3_2;
    ok4   <= ok3;
    k4    <= k3;
    cost4 <= {2'b00, sqr3} + {2'b00, sqb3} - {14'd0, l3_3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign stat.pipe_busy = v1 | v2 | v3 | v4;

  // strict less-than keeps the earliest triple on ties
  assign better = v4 && ok4 && (!best_found || ($signed(cost4) < $signed(best)));

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (cmd.job_load) begin
      best_found <= 1'b0;
    end else if (better) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best   <= cost4;
      best_i <= cur_i;
      best_j <= cur_j;
      best_k <= k4;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found        <= best_found;
      cost         <= best_found ? $signed(best) : 30'sd0;
      first_index  <= best_found ? IDX_W'(best_i) : '0;
      second_index <= best_found ? IDX_W'(best_j) : '0;
      third_index  <= best_found ? IDX_W'(best_k) : '0;
    end
  end

endmodule

// File: hw/rtl/bnts_ctrl.sv
// ----------------------------------------------------------------------------
// bnts_ctrl
// Sequencer: takes node and job beats, walks i, j, k over the store and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module bnts_ctrl import bnts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic kind,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  stat_t stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LD_I   = 3'd1;
  localparam logic [2:0] S_CAP_I  = 3'd2;
  localparam logic [2:0] S_LD_J   = 3'd3;
  localparam logic [2:0] S_CAP_J  = 3'd4;
  localparam logic [2:0] S_RUN_K  = 3'd5;
  localparam logic [2:0] S_DRAIN  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_m1;
  logic [NODE_AW-1:0] last;
  logic [NODE_AW-1:0] i;
  logic [NODE_AW-1:0] j;
  logic [NODE_AW-1:0] k;
  logic               accept;
  logic               full;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(MAX_NODES));
  assign count_m1 = count - CNT_W'(1);
  assign last     = count_m1[NODE_AW-1:0];

  always_comb begin
    cmd          = '0;
    cmd.wr_en    = accept && (kind == KIND_NODE) && !full;
    cmd.wr_addr  = count[NODE_AW-1:0];
    cmd.job_load = accept && (kind == KIND_JOB);
    cmd.rd_addr  = (state == S_LD_I) ? i : ((state == S_LD_J) ? j : k);
    cmd.cap_a    = (state == S_CAP_I);
    cmd.cap_b    = (state == S_CAP_J);
    cmd.pair_ne  = (j != i);
    cmd.issue    = (state == S_RUN_K);
    cmd.k_ne     = (k != j);
    cmd.i_idx    = i;
    cmd.j_idx    = j;
    cmd.k_idx    = k;
    cmd.out_load = (state == S_FINISH) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.job_load) begin
          state_next = (count == '0) ? S_FINISH : S_LD_I;
        end
      end
      S_LD_I:  state_next = S_CAP_I;
      S_CAP_I: state_next = S_LD_J;
      S_LD_J:  state_next = S_CAP_J;
      S_CAP_J: state_next = S_RUN_K;
      S_RUN_K: begin
        if (k == last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          if (j != last) begin
            state_next = S_LD_J;
          end else if (i != last) begin
            state_next = S_LD_I;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (cmd.out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
    end else begin
      state <= state_next;

      if (cmd.wr_en) begin
        count <= count + CNT_W'(1);
      end else if (cmd.out_load) begin
        count <= '0;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.job_load) begin
        i <= '0;
      end
      if (state == S_CAP_I) begin
        j <= i;
      end
      if (state == S_CAP_J) begin
        k <= j;
      end
      if (state == S_RUN_K && k != last) begin
        k <= k + NODE_AW'(1);
      end
      if (state == S_DRAIN && !stat.pipe_busy) begin
        if (j != last) begin
          j <= j + NODE_AW'(1);
        end else if (i != last) begin
          i <= i + NODE_AW'(1);
        end
      end
    end
  end

endmodule
